### design/cdoy_pkg.sv
`timescale 1ns / 1ps

package cdoy_pkg;

  localparam int YEAR_BITS   = 16;
  localparam int MONTH_BITS  = 4;
  localparam int MDAY_BITS   = 6;
  localparam int YDAY_BITS   = 9;
  localparam int DOUT_BITS   = 5;
  localparam int MONTHS      = 12;

  // year / 25 as (year * RECIP) >> RECIP_SHIFT, exact over the whole year range
  localparam int RECIP_SHIFT = 21;
  localparam int RECIP_BITS  = 17;
  localparam int RECIP       = (1 << RECIP_SHIFT) / 25 + 1;
  localparam int CENT_DIV    = 25;

  typedef enum logic [2:0] {
    ST_OK        = 3'd0,
    ST_BAD_YEAR  = 3'd1,
    ST_BAD_MONTH = 3'd2,
    ST_BAD_MDAY  = 3'd3,
    ST_BAD_YDAY  = 3'd4
  } status_t;

  // common-year month lengths and days before each month, index 0 unused
  localparam logic [DOUT_BITS-1:0] MONTH_DAYS [0:MONTHS] =
    '{5'd0, 5'd31, 5'd28, 5'd31, 5'd30, 5'd31, 5'd30,
      5'd31, 5'd31, 5'd30, 5'd31, 5'd30, 5'd31};

  localparam logic [YDAY_BITS-1:0] DAYS_BEFORE [0:MONTHS] =
    '{9'd0, 9'd0, 9'd31, 9'd59, 9'd90, 9'd120, 9'd151,
      9'd181, 9'd212, 9'd243, 9'd273, 9'd304, 9'd334};

  function automatic logic [DOUT_BITS-1:0] month_len(input logic leap,
                                                      input logic [MONTH_BITS-1:0] m);
    logic [DOUT_BITS-1:0] len;
    if (m > MONTH_BITS'(MONTHS)) len = '0;
    else len = MONTH_DAYS[m];
    if (leap && m == MONTH_BITS'(2)) len = len + DOUT_BITS'(1);
    return len;
  endfunction

  function automatic logic [YDAY_BITS-1:0] days_before(input logic leap,
                                                        input logic [MONTH_BITS-1:0] m);
    logic [YDAY_BITS-1:0] cnt;
    if (m > MONTH_BITS'(MONTHS)) cnt = '0;
    else cnt = DAYS_BEFORE[m];
    if (leap && m > MONTH_BITS'(2) && m <= MONTH_BITS'(MONTHS)) cnt = cnt + YDAY_BITS'(1);
    return cnt;
  endfunction

endpackage

### design/cdoy_leap.sv
`timescale 1ns / 1ps

module cdoy_leap (
  input  logic                           clk,
  input  logic [cdoy_pkg::YEAR_BITS-1:0] year,
  output logic                           leap,
  output logic                           year_zero
);
  import cdoy_pkg::*;

  localparam int PROD_BITS = YEAR_BITS + RECIP_BITS;
  localparam int QUOT_BITS = PROD_BITS - RECIP_SHIFT;

  logic [YEAR_BITS-1:0] year_a;
  logic [PROD_BITS-1:0] prod_a;
  logic [QUOT_BITS-1:0] quot;
  logic [YEAR_BITS-1:0] quot_x25;
  logic                 div25;
  logic                 leap_next;

  always_ff @(posedge clk) begin
    year_a <= year;
    prod_a <= PROD_BITS'(year) * PROD_BITS'(RECIP);
  end

  always_comb begin
    quot      = prod_a[PROD_BITS-1:RECIP_SHIFT];
    quot_x25  = YEAR_BITS'(quot) * YEAR_BITS'(CENT_DIV);
    div25     = (quot_x25 == year_a);
    // div by 4 and not 100, or div by 400 (= 16 and 25)
    leap_next = (year_a[1:0] == 2'b00 && !div25) || (year_a[3:0] == 4'b0000 && div25);
  end

  always_ff @(posedge clk) begin
    leap      <= leap_next;
    year_zero <= (year_a == '0);
  end

endmodule

### design/calendar_day_of_year_convert.sv
`timescale 1ns / 1ps

// Gregorian date / day-of-year converter.
// A request is taken at a rising edge with start high and busy low. req_type 0
// turns year, month and day_of_month into day_number; req_type 1 turns year and
// year_day into month_out and day_out. is_leap always reports the year's leap
// flag; a bad field gives a nonzero status and zeroed day_number, month_out and
// day_out.
// Each request gives one result, shown for exactly one cycle with done high.
// The result registers load together with done, from the month search and status
// registers. A new request may enter every cycle while busy is low: four register
// stages (input and year*reciprocal product, leap flag, month search and status,
// final add/subtract) carry valid bits with the data. busy is high only during and
// just after reset; the receiver cannot stall results, so the pipeline never holds.
// Reset drops every request in flight.
module calendar_day_of_year_convert (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  output logic                            busy,
  input  logic                            req_type,
  input  logic [cdoy_pkg::YEAR_BITS-1:0]  year,
  input  logic [cdoy_pkg::MONTH_BITS-1:0] month,
  input  logic [cdoy_pkg::MDAY_BITS-1:0]  day_of_month,
  input  logic [cdoy_pkg::YDAY_BITS-1:0]  year_day,
  output logic                            done,
  output logic [2:0]                      status,
  output logic [cdoy_pkg::YDAY_BITS-1:0]  day_number,
  output logic [cdoy_pkg::MONTH_BITS-1:0] month_out,
  output logic [cdoy_pkg::DOUT_BITS-1:0]  day_out,
  output logic                            is_leap
);
  import cdoy_pkg::*;

  // stage 1
  logic                  v1, req1;
  logic [MONTH_BITS-1:0] month1;
  logic [MDAY_BITS-1:0]  mday1;
  logic [YDAY_BITS-1:0]  yday1;
  // stage 2
  logic                  v2, req2;
  logic [MONTH_BITS-1:0] month2;
  logic [MDAY_BITS-1:0]  mday2;
  logic [YDAY_BITS-1:0]  yday2;
  logic                  leap2, yzero2;
  // stage 3
  logic                  v3, req3, leap3;
  status_t               status3, status3_next;
  logic [MONTH_BITS-1:0] mon3, mon3_next;
  logic [MDAY_BITS-1:0]  mday3;
  logic [YDAY_BITS-1:0]  yday3;

  logic [MONTHS-2:0]     past_end;
  logic [MONTH_BITS-1:0] found_month;
  logic [YDAY_BITS-1:0]  yday_limit;
  logic [YDAY_BITS-1:0]  before3;
  logic [YDAY_BITS-1:0]  day_number_next;
  logic [MONTH_BITS-1:0] month_out_next;
  logic [DOUT_BITS-1:0]  day_out_next;

  cdoy_leap u_leap (
    .clk       (clk),
    .year      (year),
    .leap      (leap2),
    .year_zero (yzero2)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b1;
      v1   <= 1'b0;
      v2   <= 1'b0;
      v3   <= 1'b0;
      done <= 1'b0;
    end else begin
      busy <= 1'b0;
      v1   <= start && !busy;
      v2   <= v1;
      v3   <= v2;
      done <= v3;
    end
  end

  always_ff @(posedge clk) begin
    req1   <= req_type;
    month1 <= month;
    mday1  <= day_of_month;
    yday1  <= year_day;
    req2   <= req1;
    month2 <= month1;
    mday2  <= mday1;
    yday2  <= yday1;
  end

  // month search: count month ends that the day of year lies beyond
  always_comb begin
    for (int k = 1; k < MONTHS; k++) begin
      past_end[k-1] = yday2 > days_before(leap2, MONTH_BITS'(k + 1));
    end
    found_month = MONTH_BITS'($countones(past_end)) + MONTH_BITS'(1);
    yday_limit  = leap2 ? YDAY_BITS'(366) : YDAY_BITS'(365);

    status3_next = ST_OK;
    mon3_next    = month2;
    if (!req2) begin
      if (yzero2) begin
        status3_next = ST_BAD_YEAR;
      end else if (month2 < MONTH_BITS'(1) || month2 > MONTH_BITS'(MONTHS)) begin
        status3_next = ST_BAD_MONTH;
      end else if (mday2 < MDAY_BITS'(1) ||
                   mday2 > MDAY_BITS'(month_len(leap2, month2))) begin
        status3_next = ST_BAD_MDAY;
      end
    end else begin
      mon3_next = found_month;
      if (yday2 < YDAY_BITS'(1) || yday2 > yday_limit) begin
        status3_next = ST_BAD_YDAY;
      end else if (yzero2) begin
        status3_next = ST_BAD_YEAR;
      end
    end
  end

  always_ff @(posedge clk) begin
    req3    <= req2;
    leap3   <= leap2;
    status3 <= status3_next;
    mon3    <= mon3_next;
    mday3   <= mday2;
    yday3   <= yday2;
  end

  always_comb begin
    before3         = days_before(leap3, mon3);
    day_number_next = '0;
    month_out_next  = '0;
    day_out_next    = '0;
    if (status3 == ST_OK) begin
      if (!req3) begin
        day_number_next = before3 + YDAY_BITS'(mday3);
      end else begin
        month_out_next = mon3;
        day_out_next   = DOUT_BITS'(yday3 - before3);
      end
    end
  end

  always_ff @(posedge clk) begin
    status     <= status3;
    day_number <= day_number_next;
    month_out  <= month_out_next;
    day_out    <= day_out_next;
    is_leap    <= leap3;
  end

`ifndef SYNTHESIS
  a_latency: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |-> ##4 done)
    else $error("request did not give a result four cycles later");

  a_err_zero: assert property (@(posedge clk) disable iff (rst)
    (done && status != ST_OK) |-> (day_number == '0 && month_out == '0 && day_out == '0))
    else $error("error result carries nonzero values");

  a_status_range: assert property (@(posedge clk) disable iff (rst)
    done |-> (status == ST_OK || status == ST_BAD_YEAR || status == ST_BAD_MONTH ||
              status == ST_BAD_MDAY || status == ST_BAD_YDAY))
    else $error("status code out of range");

  a_date_ok: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_OK && month_out != '0) |->
      (day_out != '0 && month_out <= MONTH_BITS'(MONTHS) && day_number == '0))
    else $error("day of year conversion gave an impossible date");
`endif

endmodule

### sim/cdoy_checker.sv
`timescale 1ns / 1ps

module cdoy_checker (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic                            busy,
  input  logic                            req_type,
  input  logic [cdoy_pkg::YEAR_BITS-1:0]  year,
  input  logic [cdoy_pkg::MONTH_BITS-1:0] month,
  input  logic [cdoy_pkg::MDAY_BITS-1:0]  day_of_month,
  input  logic [cdoy_pkg::YDAY_BITS-1:0]  year_day,
  input  logic                            done,
  input  logic [2:0]                      status,
  input  logic [cdoy_pkg::YDAY_BITS-1:0]  day_number,
  input  logic [cdoy_pkg::MONTH_BITS-1:0] month_out,
  input  logic [cdoy_pkg::DOUT_BITS-1:0]  day_out,
  input  logic                            is_leap,
  output int                              fail_count,
  output int                              pending_count
);

  import cdoy_pkg::*;

  typedef struct {
    status_t                status;
    logic [YDAY_BITS-1:0]   day_number;
    logic [MONTH_BITS-1:0]  month_out;
    logic [DOUT_BITS-1:0]   day_out;
    logic                   is_leap;
  } conv_result_t;

  conv_result_t conversions_due [$];

  function automatic int days_in_month(logic leap, int m);
    case (m)
      2:             return leap ? 29 : 28;
      4, 6, 9, 11:   return 30;
      default:       return 31;
    endcase
  endfunction

  function automatic conv_result_t convert_date(logic rt, logic [YEAR_BITS-1:0] yr,
                                                logic [MONTH_BITS-1:0] mo,
                                                logic [MDAY_BITS-1:0] md,
                                                logic [YDAY_BITS-1:0] yd);
    conv_result_t r;
    int y;
    int total;
    int rem;
    int m;
    int limit;
    logic leap;
    y    = int'(yr);
    leap = ((y % 4 == 0) && (y % 100 != 0)) || (y % 400 == 0);
    r.status     = ST_OK;
    r.day_number = '0;
    r.month_out  = '0;
    r.day_out    = '0;
    r.is_leap    = leap;
    if (!rt) begin
      if (y == 0) begin
        r.status = ST_BAD_YEAR;
      end else if (mo < 1 || mo > MONTHS) begin
        r.status = ST_BAD_MONTH;
      end else if (md < 1 || int'(md) > days_in_month(leap, int'(mo))) begin
        r.status = ST_BAD_MDAY;
      end else begin
        total = int'(md);
        for (m = 1; m < int'(mo); m++) total += days_in_month(leap, m);
        r.day_number = total[YDAY_BITS-1:0];
      end
    end else begin
      limit = leap ? 366 : 365;
      if (yd < 1 || int'(yd) > limit) begin
        r.status = ST_BAD_YDAY;
      end else if (y == 0) begin
        r.status = ST_BAD_YEAR;
      end else begin
        rem = int'(yd);
        m   = 1;
        // walk the months, never past december
        while (m < MONTHS && rem > days_in_month(leap, m)) begin
          rem -= days_in_month(leap, m);
          m++;
        end
        r.month_out = m[MONTH_BITS-1:0];
        r.day_out   = rem[DOUT_BITS-1:0];
      end
    end
    return r;
  endfunction

  always @(posedge clk) begin : watch
    conv_result_t want;
    if (rst) begin
      conversions_due.delete();
      fail_count = 0;
    end else begin
      if (start && !busy)
        conversions_due.push_back(convert_date(req_type, year, month, day_of_month, year_day));
      if (done) begin
        if (conversions_due.size() == 0) begin
          $display("%0t: result with no request outstanding", $time);
          fail_count++;
        end else begin
          want = conversions_due.pop_front();
          if (status !== want.status) begin
            $display("%0t: status expected %0d got %0d", $time, want.status, status);
            fail_count++;
          end
          if (day_number !== want.day_number) begin
            $display("%0t: day_number expected %0d got %0d", $time, want.day_number,
                     day_number);
            fail_count++;
          end
          if (month_out !== want.month_out) begin
            $display("%0t: month_out expected %0d got %0d", $time, want.month_out,
                     month_out);
            fail_count++;
          end
          if (day_out !== want.day_out) begin
            $display("%0t: day_out expected %0d got %0d", $time, want.day_out, day_out);
            fail_count++;
          end
          if (is_leap !== want.is_leap) begin
            $display("%0t: is_leap expected %0d got %0d", $time, want.is_leap, is_leap);
            fail_count++;
          end
        end
      end
    end
    pending_count <= conversions_due.size();
  end

endmodule

### sim/tb_calendar_day_of_year_convert.sv
`timescale 1ns / 1ps

module tb_calendar_day_of_year_convert;

  import cdoy_pkg::*;

  localparam int RANDOM_ITEMS   = 1450;
  localparam int WATCHDOG_LIMIT = 2000;
  localparam int DRAIN_CYCLES   = 10;

  logic                  clk          = 1'b0;
  logic                  rst          = 1'b1;
  logic                  start        = 1'b0;
  logic                  req_type     = 1'b0;
  logic [YEAR_BITS-1:0]  year         = '0;
  logic [MONTH_BITS-1:0] month        = '0;
  logic [MDAY_BITS-1:0]  day_of_month = '0;
  logic [YDAY_BITS-1:0]  year_day     = '0;
  logic                  busy;
  logic                  done;
  logic [2:0]            status;
  logic [YDAY_BITS-1:0]  day_number;
  logic [MONTH_BITS-1:0] month_out;
  logic [DOUT_BITS-1:0]  day_out;
  logic                  is_leap;

  int fail_count;
  int pending_count;
  int idle_cycles = 0;

  calendar_day_of_year_convert u_dut (
    .clk          (clk),
    .rst          (rst),
    .start        (start),
    .busy         (busy),
    .req_type     (req_type),
    .year         (year),
    .month        (month),
    .day_of_month (day_of_month),
    .year_day     (year_day),
    .done         (done),
    .status       (status),
    .day_number   (day_number),
    .month_out    (month_out),
    .day_out      (day_out),
    .is_leap      (is_leap)
  );

  cdoy_checker u_checker (
    .clk           (clk),
    .rst           (rst),
    .start         (start),
    .busy          (busy),
    .req_type      (req_type),
    .year          (year),
    .month         (month),
    .day_of_month  (day_of_month),
    .year_day      (year_day),
    .done          (done),
    .status        (status),
    .day_number    (day_number),
    .month_out     (month_out),
    .day_out       (day_out),
    .is_leap       (is_leap),
    .fail_count    (fail_count),
    .pending_count (pending_count)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // no progress on either side for too long means the block has hung
  always @(posedge clk) begin
    if (rst || (start && !busy) || done) idle_cycles <= 0;
    else idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WATCHDOG_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  // holds start high until the request is taken
  task automatic send_request(logic rt, logic [YEAR_BITS-1:0] yr, logic [MONTH_BITS-1:0] mo,
                              logic [MDAY_BITS-1:0] md, logic [YDAY_BITS-1:0] yd);
    req_type     <= rt;
    year         <= yr;
    month        <= mo;
    day_of_month <= md;
    year_day     <= yd;
    start        <= 1'b1;
    do @(posedge clk); while (busy);
  endtask

  // bias towards century and leap boundaries
  function automatic logic [YEAR_BITS-1:0] pick_year();
    int sel;
    sel = $urandom_range(0, 9);
    case (sel)
      0:       return YEAR_BITS'($urandom_range(0, 163) * 400);
      1:       return YEAR_BITS'($urandom_range(0, 655) * 100);
      2:       return YEAR_BITS'($urandom_range(0, 16383) * 4);
      3: begin
        if ($urandom_range(0, 2) == 0) return '0;
        else if ($urandom_range(0, 1) == 1) return '1;
        else return YEAR_BITS'(1);
      end
      default: return YEAR_BITS'($urandom_range(1, 65535));
    endcase
  endfunction

  task automatic send_random_item();
    logic                  rt;
    logic [YEAR_BITS-1:0]  yr;
    logic [MONTH_BITS-1:0] mo;
    logic [MDAY_BITS-1:0]  md;
    logic [YDAY_BITS-1:0]  yd;
    int                    edge_pick;
    rt = 1'($urandom_range(0, 1));
    yr = pick_year();
    mo = MONTH_BITS'($urandom_range(0, 15));
    md = MDAY_BITS'($urandom_range(0, 63));
    yd = YDAY_BITS'($urandom_range(0, 511));
    if ($urandom_range(0, 9) < 8) begin
      // mostly well-formed request, unused fields left as noise
      if (!rt) begin
        mo = MONTH_BITS'($urandom_range(1, 12));
        if ($urandom_range(0, 3) == 0) begin
          edge_pick = $urandom_range(0, 4);
          md = MDAY_BITS'(28 + edge_pick);
        end else begin
          md = MDAY_BITS'($urandom_range(1, 31));
        end
      end else begin
        if ($urandom_range(0, 3) == 0) begin
          edge_pick = $urandom_range(0, 5);
          case (edge_pick)
            0:       yd = YDAY_BITS'(1);
            1:       yd = YDAY_BITS'(59);
            2:       yd = YDAY_BITS'(60);
            3:       yd = YDAY_BITS'(365);
            4:       yd = YDAY_BITS'(366);
            default: yd = YDAY_BITS'(367);
          endcase
        end else begin
          yd = YDAY_BITS'($urandom_range(1, 366));
        end
      end
    end
    send_request(rt, yr, mo, md, yd);
  endtask

  initial begin
    int sent;
    int burst;
    int gap;
    repeat (10) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // date to day of year
    send_request(1'b0, 16'd0,     4'd1,  6'd1,  9'd0);
    send_request(1'b0, 16'd2024,  4'd12, 6'd31, 9'd511);
    send_request(1'b0, 16'd2023,  4'd12, 6'd31, 9'd0);
    send_request(1'b0, 16'd2024,  4'd2,  6'd29, 9'd0);
    send_request(1'b0, 16'd2023,  4'd2,  6'd29, 9'd0);
    send_request(1'b0, 16'd1900,  4'd2,  6'd29, 9'd0);
    send_request(1'b0, 16'd2000,  4'd2,  6'd29, 9'd0);
    send_request(1'b0, 16'd2024,  4'd0,  6'd1,  9'd0);
    send_request(1'b0, 16'd2024,  4'd13, 6'd1,  9'd0);
    send_request(1'b0, 16'd65535, 4'd15, 6'd63, 9'd511);
    send_request(1'b0, 16'd2024,  4'd1,  6'd0,  9'd0);
    send_request(1'b0, 16'd2024,  4'd4,  6'd31, 9'd0);
    send_request(1'b0, 16'd65535, 4'd1,  6'd1,  9'd511);
    send_request(1'b0, 16'd1,     4'd3,  6'd1,  9'd0);
    // day of year to date
    send_request(1'b1, 16'd2024,  4'd0,  6'd0,  9'd366);
    send_request(1'b1, 16'd2023,  4'd0,  6'd0,  9'd366);
    send_request(1'b1, 16'd2023,  4'd0,  6'd0,  9'd365);
    send_request(1'b1, 16'd2024,  4'd0,  6'd0,  9'd0);
    send_request(1'b1, 16'd2024,  4'd15, 6'd63, 9'd511);
    // year zero counts as leap, so 366 passes the day check and fails on year
    send_request(1'b1, 16'd0,     4'd0,  6'd0,  9'd366);
    send_request(1'b1, 16'd0,     4'd0,  6'd0,  9'd367);
    send_request(1'b1, 16'd2024,  4'd0,  6'd0,  9'd60);
    send_request(1'b1, 16'd2023,  4'd0,  6'd0,  9'd60);
    send_request(1'b1, 16'd1,     4'd0,  6'd0,  9'd1);
    send_request(1'b1, 16'd65535, 4'd15, 6'd63, 9'd59);
    start <= 1'b0;
    repeat (3) @(posedge clk);

    sent = 0;
    while (sent < RANDOM_ITEMS) begin
      burst = ($urandom_range(0, 7) == 0) ? $urandom_range(40, 120) : $urandom_range(1, 12);
      repeat (burst) begin
        if (sent < RANDOM_ITEMS) begin
          send_random_item();
          sent++;
        end
      end
      gap = ($urandom_range(0, 4) == 0) ? 0 : $urandom_range(1, 6);
      if (gap != 0) begin
        start <= 1'b0;
        repeat (gap) @(posedge clk);
      end
    end
    start <= 1'b0;

    while (pending_count != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    if (fail_count == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
